// ----- hdl/pit3_pkg.sv -----
// Shared types and constants of the three-counter interval timer.
// No dependencies.
package pit3_pkg;

    localparam int CNT_W = 16;

    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_READ    = 2'd1,
        REQ_ADVANCE = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    localparam logic [1:0] ADDR_CTRL = 2'd3;
    localparam logic [1:0] ACC_LATCH = 2'd0;
    localparam logic [1:0] ACC_HIGH  = 2'd2;
    localparam logic [1:0] ACC_BOTH  = 2'd3;
    localparam logic [2:0] MODE_ONESHOT = 3'd0;
    localparam logic [2:0] MODE_SQUARE  = 3'd3;
    localparam logic [2:0] MODE_ALIAS3  = 3'd7;
    localparam logic [7:0] BYTE_ABSENT  = 8'hFF;

    typedef struct packed {
        t_req        req;
        logic [1:0]  addr;
        logic [7:0]  data;
        logic [15:0] ticks;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MOD  = 2'd1,
        ST_APPLY = 2'd2,
        ST_OUT  = 2'd3
    } t_state;

endpackage

// ----- hdl/pit3_front.sv -----
// Front end: accepts input transfers and holds them in a two-entry queue.
// Depends on pit3_pkg.
module pit3_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  pit3_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output pit3_pkg::t_cmd o_cmd
);
    import pit3_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_cmd   = r_mem[r_rp];

    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end
endmodule

// ----- hdl/pit3_mod.sv -----
// Restoring 16-bit modulo unit, one quotient bit per cycle.
// Depends on pit3_pkg.
module pit3_mod (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_done,
    output logic [15:0] o_rem
);
    import pit3_pkg::*;

    logic [16:0] r_rem, n_rem;
    logic [15:0] r_num, n_num;
    logic [15:0] r_den;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [16:0] shifted;

    assign shifted = {r_rem[15:0], r_num[15]};
    assign o_done  = r_busy && (r_cnt == 5'd0);
    assign o_rem   = r_rem[15:0];

    always_comb begin
        n_rem  = r_rem;
        n_num  = r_num;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_start) begin
            n_rem  = '0;
            n_num  = i_num;
            n_cnt  = 5'd16;
            n_busy = 1'b1;
        end else if (r_busy && r_cnt != 5'd0) begin
            n_num = {r_num[14:0], 1'b0};
            n_rem = (shifted >= {1'b0, r_den}) ? shifted - {1'b0, r_den} : shifted;
            n_cnt = r_cnt - 5'd1;
        end else if (o_done) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_num <= n_num;
        if (i_start) begin
            r_den <= i_den;
        end
    end
endmodule

// ----- hdl/pit3_back.sv -----
// Back end: counter state, register access and time advance per counter.
// Depends on pit3_pkg and pit3_mod.
module pit3_back #(
    parameter int NUM_COUNTERS = 3
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  pit3_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [10:0]    o_data
);
    import pit3_pkg::*;

    t_state      r_state, n_state;
    t_cmd        r_cmd;
    logic [1:0]  r_ch;
    logic [7:0]  r_rd;
    logic        r_ovalid;
    logic [10:0] r_odata;

    logic [15:0] r_cv [3];
    logic [15:0] r_rv [3];
    logic [15:0] r_lv [3];
    logic [2:0]  r_md [3];
    logic [1:0]  r_am [3];
    logic        r_run [3];
    logic        r_rh [3];
    logic        r_wh [3];
    logic        r_lh [3];
    logic        r_bcd [3];
    logic        r_out [3];
    logic [7:0]  r_cw [3];

    logic        mod_start, mod_done;
    logic [15:0] mod_rem;
    logic        need_mod;
    logic [15:0] rd_src;

    function automatic logic present(input logic [1:0] c);
        return (c != 2'd3) && (int'(c) < NUM_COUNTERS);
    endfunction

    pit3_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_num   (r_cmd.ticks),
        .i_den   (r_rv[r_ch]),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    assign need_mod = present(r_ch) && r_run[r_ch] && (r_md[r_ch] == MODE_SQUARE)
                      && (r_rv[r_ch] >= 16'd3);
    assign o_ready  = (r_state == ST_IDLE);
    assign o_valid  = r_ovalid;
    assign o_data   = r_odata;
    assign rd_src   = r_lh[r_ch] ? r_lv[r_ch] : r_cv[r_ch];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_valid) n_state = (i_cmd.req == REQ_ADVANCE) ? ST_MOD : ST_APPLY;
            ST_MOD: begin
                if (!need_mod) n_state = (r_ch == 2'd2) ? ST_OUT : ST_MOD;
                else if (mod_done) n_state = (r_ch == 2'd2) ? ST_OUT : ST_MOD;
            end
            ST_APPLY: n_state = ST_OUT;
            ST_OUT: if (!r_ovalid || i_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    logic r_mstarted;
    always_comb begin
        mod_start = (r_state == ST_MOD) && need_mod && !r_mstarted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_ovalid   <= 1'b0;
            r_mstarted <= 1'b0;
            r_ch       <= 2'd0;
            for (int c = 0; c < 3; c++) begin
                r_cv[c] <= '0; r_rv[c] <= '0; r_lv[c] <= '0; r_md[c] <= '0;
                r_am[c] <= ACC_LATCH; r_run[c] <= 1'b0; r_rh[c] <= 1'b0;
                r_wh[c] <= 1'b0; r_lh[c] <= 1'b0; r_bcd[c] <= 1'b0; r_out[c] <= 1'b1;
            end
            r_cw[0] <= 8'h10; r_cw[1] <= 8'h50; r_cw[2] <= 8'h90;
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT && (!r_ovalid || i_ready)) r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_cmd <= i_cmd;
                        r_rd  <= 8'd0;
                        r_mstarted <= 1'b0;
                        r_ch  <= (i_cmd.req == REQ_ADVANCE) ? 2'd0 :
                                 (i_cmd.req == REQ_WRITE && i_cmd.addr == ADDR_CTRL)
                                     ? i_cmd.data[7:6] : i_cmd.addr;
                    end
                end
                ST_MOD: begin
                    if (present(r_ch)) begin
                        if (r_run[r_ch] && r_md[r_ch] == MODE_ONESHOT) begin
                            if (r_cv[r_ch] < r_cmd.ticks) begin
                                r_out[r_ch] <= 1'b1;
                                r_run[r_ch] <= 1'b0;
                            end
                            r_cv[r_ch] <= r_cv[r_ch] - r_cmd.ticks;
                        end else if (r_run[r_ch] && r_md[r_ch] == MODE_SQUARE) begin
                            if (mod_start) r_mstarted <= 1'b1;
                            if (mod_done) begin
                                if (r_cv[r_ch] < mod_rem) begin
                                    r_cv[r_ch] <= r_cv[r_ch] + r_rv[r_ch] - mod_rem;
                                    r_out[r_ch] <= ((r_cv[r_ch] + r_rv[r_ch] - mod_rem)
                                                    >= {1'b0, r_rv[r_ch][15:1]});
                                end else begin
                                    r_cv[r_ch] <= r_cv[r_ch] - mod_rem;
                                    r_out[r_ch] <= ((r_cv[r_ch] - mod_rem)
                                                    >= {1'b0, r_rv[r_ch][15:1]});
                                end
                            end
                        end else begin
                            r_cv[r_ch] <= r_cv[r_ch] - r_cmd.ticks;
                        end
                    end
                    if (!need_mod || mod_done) begin
                        r_mstarted <= 1'b0;
                        if (r_ch != 2'd2) r_ch <= r_ch + 2'd1;
                    end
                end
                ST_APPLY: begin
                    if (r_cmd.req == REQ_READ) begin
                        if (!present(r_ch)) r_rd <= BYTE_ABSENT;
                        else if (!r_rh[r_ch]) begin
                            r_rh[r_ch] <= 1'b1;
                            r_rd <= rd_src[7:0];
                        end else begin
                            r_rh[r_ch] <= 1'b0;
                            r_lh[r_ch] <= 1'b0;
                            r_rd <= rd_src[15:8];
                        end
                    end else if (r_cmd.req == REQ_WRITE && present(r_ch)) begin
                        if (r_cmd.addr == ADDR_CTRL) begin
                            if (r_cmd.data[5:4] == ACC_LATCH) begin
                                r_lv[r_ch] <= r_cv[r_ch];
                                r_lh[r_ch] <= 1'b1;
                                r_rh[r_ch] <= 1'b0;
                            end else begin
                                r_cw[r_ch]  <= r_cmd.data;
                                r_md[r_ch]  <= (r_cmd.data[3:1] == MODE_ALIAS3) ? MODE_SQUARE
                                               : r_cmd.data[3:1];
                                r_am[r_ch]  <= r_cmd.data[5:4];
                                r_bcd[r_ch] <= r_cmd.data[0];
                                r_lh[r_ch]  <= 1'b0;
                                r_run[r_ch] <= 1'b0;
                                r_wh[r_ch]  <= (r_cmd.data[5:4] == ACC_HIGH);
                                r_rh[r_ch]  <= 1'b0;
                                r_cv[r_ch]  <= '0;
                                r_rv[r_ch]  <= '0;
                                if (r_cmd.data[3:1] == MODE_ONESHOT) r_out[r_ch] <= 1'b0;
                            end
                        end else begin
                            logic [15:0] nrv;
                            logic        go;
                            nrv = r_wh[r_ch] ? {r_cmd.data, r_rv[r_ch][7:0]}
                                             : {r_rv[r_ch][15:8], r_cmd.data};
                            go  = 1'b1;
                            r_rv[r_ch] <= nrv;
                            if (!r_wh[r_ch] && r_am[r_ch] == ACC_BOTH) begin
                                go = 1'b0;
                                r_wh[r_ch] <= 1'b1;
                                if (r_md[r_ch] == MODE_ONESHOT) begin
                                    r_run[r_ch] <= 1'b0;
                                    r_out[r_ch] <= 1'b1;
                                end
                            end else if (r_wh[r_ch] && r_am[r_ch] == ACC_BOTH) begin
                                r_wh[r_ch] <= 1'b0;
                            end
                            if (go && (!r_run[r_ch] || r_md[r_ch] == MODE_ONESHOT)) begin
                                r_run[r_ch] <= 1'b1;
                                r_cv[r_ch]  <= nrv;
                                if (r_md[r_ch] == MODE_SQUARE) r_out[r_ch] <= 1'b1;
                                else if (r_md[r_ch] == MODE_ONESHOT) r_out[r_ch] <= 1'b0;
                            end
                        end
                    end
                end
                ST_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_odata  <= {present(2'd2) ? r_out[2] : 1'b1,
                                     present(2'd1) ? r_out[1] : 1'b1,
                                     present(2'd0) ? r_out[0] : 1'b1,
                                     (r_cmd.req == REQ_READ && r_cmd.addr == ADDR_CTRL)
                                         ? BYTE_ABSENT : r_rd};
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ----- hdl/programmable_interval_timer_3ch_unit.sv -----
// Three-counter interval timer, top level.
// Reads and writes pass states IDLE, APPLY, OUT; tick transfers pass IDLE, MOD, OUT,
// using the shared 16-step modulo unit once per running square-wave counter (reload >= 3).
// One transfer is processed at a time; a 2-entry input queue absorbs arrivals.
// Synchronous active-low reset: all counters stopped, outputs high.
// Depends on pit3_pkg, pit3_front, pit3_back.
module programmable_interval_timer_3ch_unit #(
    parameter int NUM_COUNTERS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,   // req_type
    input  logic [31:0] s_axis_tdata,   // reg_addr[1:0], write_data[9:2], tick_count[25:10]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // read_data[7:0], out_zero, out_one, out_two
);
    import pit3_pkg::*;

    t_cmd        in_cmd, q_cmd;
    logic        q_valid, q_ready;
    logic [10:0] odata;

    assign in_cmd = '{req: t_req'(s_axis_tuser), addr: s_axis_tdata[1:0],
                      data: s_axis_tdata[9:2], ticks: s_axis_tdata[25:10]};
    assign m_axis_tdata = {5'd0, odata};

    pit3_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_cmd(in_cmd),
        .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd)
    );

    pit3_back #(.NUM_COUNTERS(NUM_COUNTERS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_cmd(q_cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(odata)
    );

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");
endmodule

// ----- verif/programmable_interval_timer_3ch_unit_tb.sv -----
// Testbench for the three-counter interval timer: directed table, then random traffic.
// Every result is checked against an in-bench timer model. Depends on pit3_pkg and the top level.
`timescale 1ns / 100ps
module programmable_interval_timer_3ch_unit_tb;
    import pit3_pkg::*;

    localparam int LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [1:0]  s_axis_tuser = '0;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    programmable_interval_timer_3ch_unit #(.NUM_COUNTERS(3)) dut (.*);

    always #5 i_clk = ~i_clk;

    typedef struct packed {
        logic [7:0] rd;
        logic [2:0] outs;
    } t_pit_out;

    logic [15:0] cnt_q[3], rel_q[3], lat_q[3];
    logic [2:0]  mode_q[3];
    logic [1:0]  acc_q[3];
    logic        run_q[3], rdh_q[3], wrh_q[3], held_q[3], lvl_q[3];

    t_pit_out pending_outs[$];
    int  errors = 0;
    int  cycles = 0;
    int  send_idle = 0, recv_stall = 0;

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] exp);
        errors++;
        $display("mismatch %s: got %h expected %h", what, got, exp);
    endtask

    task automatic timer_reset();
        for (int c = 0; c < 3; c++) begin
            cnt_q[c] = 0; rel_q[c] = 0; lat_q[c] = 0; mode_q[c] = 0; acc_q[c] = 0;
            run_q[c] = 0; rdh_q[c] = 0; wrh_q[c] = 0; held_q[c] = 0; lvl_q[c] = 1;
        end
    endtask

    function automatic t_pit_out timer_step(input t_req rq, input logic [1:0] a,
                                            input logic [7:0] d, input logic [15:0] n);
        t_pit_out r;
        int c;
        logic [2:0] m;
        logic [1:0] ac;
        logic [15:0] src, md;
        logic [16:0] t;
        r.rd = 0;
        if (rq == REQ_WRITE && a == ADDR_CTRL) begin
            c = d[7:6]; ac = d[5:4]; m = d[3:1];
            if (c < 3) begin
                if (m == MODE_ALIAS3) m = MODE_SQUARE;
                if (ac == ACC_LATCH) begin
                    lat_q[c] = cnt_q[c]; held_q[c] = 1; rdh_q[c] = 0;
                end else begin
                    mode_q[c] = m; acc_q[c] = ac; held_q[c] = 0; run_q[c] = 0;
                    wrh_q[c] = (ac == ACC_HIGH); rdh_q[c] = 0; cnt_q[c] = 0; rel_q[c] = 0;
                    if (m == MODE_ONESHOT) lvl_q[c] = 0;
                end
            end
        end else if (rq == REQ_WRITE) begin
            c = a;
            if (!wrh_q[c]) begin
                rel_q[c][7:0] = d;
                if (acc_q[c] == ACC_BOTH) begin
                    wrh_q[c] = 1;
                    if (mode_q[c] == MODE_ONESHOT) begin run_q[c] = 0; lvl_q[c] = 1; end
                    c = -1;
                end
            end else begin
                rel_q[c][15:8] = d;
                if (acc_q[c] == ACC_BOTH) wrh_q[c] = 0;
            end
            if (c >= 0 && (!run_q[c] || mode_q[c] == MODE_ONESHOT)) begin
                run_q[c] = 1; cnt_q[c] = rel_q[c];
                if (mode_q[c] == MODE_SQUARE) lvl_q[c] = 1;
                else if (mode_q[c] == MODE_ONESHOT) lvl_q[c] = 0;
            end
        end else if (rq == REQ_READ) begin
            if (a == ADDR_CTRL) r.rd = BYTE_ABSENT;
            else begin
                c = a;
                src = held_q[c] ? lat_q[c] : cnt_q[c];
                if (!rdh_q[c]) begin rdh_q[c] = 1; r.rd = src[7:0]; end
                else begin rdh_q[c] = 0; held_q[c] = 0; r.rd = src[15:8]; end
            end
        end else if (rq == REQ_ADVANCE) begin
            for (int k = 0; k < 3; k++) begin
                if (run_q[k] && mode_q[k] == MODE_ONESHOT) begin
                    if (cnt_q[k] < n) begin lvl_q[k] = 1; run_q[k] = 0; end
                    cnt_q[k] = cnt_q[k] - n;
                end else if (run_q[k] && mode_q[k] == MODE_SQUARE) begin
                    if (rel_q[k] >= 3) begin
                        md = n % rel_q[k];
                        t = (cnt_q[k] < md) ? {1'b0, cnt_q[k]} + rel_q[k] - md
                                            : {1'b0, cnt_q[k]} - md;
                        cnt_q[k] = t[15:0];
                        lvl_q[k] = (cnt_q[k] < (rel_q[k] >> 1)) ? 1'b0 : 1'b1;
                    end
                end else cnt_q[k] = cnt_q[k] - n;
            end
        end
        r.outs = {lvl_q[2], lvl_q[1], lvl_q[0]};
        return r;
    endfunction

    task automatic send(input t_req rq, input logic [1:0] a, input logic [7:0] d,
                        input logic [15:0] n, input int has_exp = 0,
                        input logic [7:0] exp_rd = 0);
        t_pit_out r;
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rq;
        s_axis_tdata  <= {6'd0, n, d, a};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        r = timer_step(rq, a, d, n);
        if (has_exp && r.rd !== exp_rd) report("table read_data", r.rd, exp_rd);
        pending_outs.push_back(r);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) m_axis_tready <= ($urandom_range(99) >= recv_stall);

    always @(posedge i_clk) begin
        t_pit_out e;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("programmable_interval_timer_3ch_unit regression: fail");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_outs.size() == 0) report("unexpected transfer", m_axis_tdata, 0);
            else begin
                e = pending_outs.pop_front();
                if (m_axis_tdata[7:0] !== e.rd) report("read_data", m_axis_tdata[7:0], e.rd);
                if (m_axis_tdata[10:8] !== e.outs) report("outs", m_axis_tdata[10:8], e.outs);
                if (m_axis_tdata[15:11] !== 0) report("pad", m_axis_tdata[15:11], 0);
            end
        end
    end

    typedef struct {
        t_req rq; logic [1:0] a; logic [7:0] d; logic [15:0] n; int chk; logic [7:0] rd;
    } t_row;

    t_row dir_rows[] = '{
        '{REQ_READ, 2'd0, 8'h00, 16'h0000, 1, 8'h00},
        '{REQ_READ, 2'd3, 8'h00, 16'h0000, 1, 8'hFF},
        '{REQ_NONE, 2'd1, 8'hFF, 16'hFFFF, 1, 8'h00},
        '{REQ_WRITE, 2'd1, 8'h05, 16'h0000, 0, 8'h00},
        '{REQ_ADVANCE, 2'd0, 8'h00, 16'hFFFF, 0, 8'h00},
        '{REQ_WRITE, 2'd3, 8'hF6, 16'h0000, 0, 8'h00},
        '{REQ_WRITE, 2'd3, 8'h30, 16'h0000, 0, 8'h00},
        '{REQ_WRITE, 2'd0, 8'h0A, 16'h0000, 0, 8'h00},
        '{REQ_WRITE, 2'd0, 8'h00, 16'h0000, 0, 8'h00},
        '{REQ_ADVANCE, 2'd0, 8'h00, 16'h000A, 0, 8'h00},
        '{REQ_ADVANCE, 2'd0, 8'h00, 16'h0001, 0, 8'h00},
        '{REQ_WRITE, 2'd3, 8'h00, 16'h0000, 0, 8'h00},
        '{REQ_READ, 2'd0, 8'h00, 16'h0000, 1, 8'hFF},
        '{REQ_READ, 2'd0, 8'h00, 16'h0000, 1, 8'hFF},
        '{REQ_WRITE, 2'd3, 8'h76, 16'h0000, 0, 8'h00},
        '{REQ_WRITE, 2'd1, 8'h02, 16'h0000, 0, 8'h00},
        '{REQ_WRITE, 2'd1, 8'h00, 16'h0000, 0, 8'h00},
        '{REQ_ADVANCE, 2'd0, 8'h00, 16'h0007, 0, 8'h00},
        '{REQ_WRITE, 2'd3, 8'hBF, 16'h0000, 0, 8'h00},
        '{REQ_WRITE, 2'd2, 8'hFF, 16'h0000, 0, 8'h00},
        '{REQ_WRITE, 2'd3, 8'hA4, 16'h0000, 0, 8'h00},
        '{REQ_WRITE, 2'd2, 8'h64, 16'h0000, 0, 8'h00},
        '{REQ_ADVANCE, 2'd0, 8'h00, 16'h1234, 0, 8'h00},
        '{REQ_READ, 2'd2, 8'h00, 16'h0000, 0, 8'h00},
        '{REQ_READ, 2'd2, 8'h00, 16'h0000, 0, 8'h00}
    };

    task automatic random_item();
        int p;
        logic [15:0] n;
        logic [7:0] cw;
        p = $urandom_range(99);
        n = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40));
        if (p < 10) begin
            cw = 8'($urandom);
            if ($urandom_range(1)) cw[3:1] = $urandom_range(1) ? MODE_SQUARE : MODE_ONESHOT;
            send(REQ_WRITE, ADDR_CTRL, cw, 16'($urandom));
        end else if (p < 30)
            send(REQ_WRITE, 2'($urandom_range(2)),
                 $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(20)), 16'($urandom));
        else if (p < 55) send(REQ_READ, 2'($urandom), 8'($urandom), 16'($urandom));
        else if (p < 97) send(REQ_ADVANCE, 2'($urandom), 8'($urandom), n);
        else send(REQ_NONE, 2'($urandom), 8'($urandom), 16'($urandom));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_outs.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        timer_reset();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_rows[i])
            send(dir_rows[i].rq, dir_rows[i].a, dir_rows[i].d, dir_rows[i].n,
                 dir_rows[i].chk, dir_rows[i].rd);
        for (int ph = 0; ph < 4; ph++) begin
            send_idle  = (ph == 1 || ph == 3) ? ((ph == 1) ? 88 : 14) : 0;
            recv_stall = (ph == 2 || ph == 3) ? ((ph == 2) ? 88 : 14) : 0;
            for (int i = 0; i < 350; i++) begin
                random_item();
                if (i == 175) drain();
            end
        end
        drain();
        if (errors == 0) $display("programmable_interval_timer_3ch_unit regression: pass");
        else $display("programmable_interval_timer_3ch_unit regression: fail");
        $finish;
    end
endmodule
